FILE: src/gmb_pkg.sv
// gmb_pkg: shared constants and register codes for the golomb encoder
// no dependencies; used by every module of the block
package gmb_pkg;

  localparam int DIV_W       = 16;  // divisor register width
  localparam int B_W         = 4;   // floor(log2 m)
  localparam int LEN_W       = 5;   // remainder / tail lengths, 0..17
  localparam int TAIL_W      = DIV_W + 1;  // terminating one plus remainder code
  localparam int CODE_W      = 32;
  localparam int CNT_W       = 6;
  localparam int MAX_RESULTS = 64;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIVISOR     = 1'b0,
    REG_SIGNED_MODE = 1'b1
  } cfg_reg_t;

endpackage

FILE: src/gmb_in_if.sv
// gmb_in_if: valid/ready channel carrying one value to be coded
// depends on nothing; VALUE_BITS sets the payload width
interface gmb_in_if #(
  parameter int VALUE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

FILE: src/gmb_out_if.sv
// gmb_out_if: valid/ready channel carrying one code segment
// depends on gmb_pkg for field widths
interface gmb_out_if;
  logic                         valid;
  logic                         ready;
  logic [gmb_pkg::CODE_W-1:0]   code_bits;
  logic [gmb_pkg::CNT_W-1:0]    bit_count;
  logic                         last;
  logic                         overflow;

  modport source (output valid, output code_bits, output bit_count, output last,
                  output overflow, input ready);
  modport sink   (input valid, input code_bits, input bit_count, input last,
                  input overflow, output ready);
endinterface

FILE: src/golomb_encoder.sv
// golomb_encoder: from request to first segment a value passes the fold register,
// one divider stage per quotient bit, the code stage, the segment splitter and
// the output register
// throughput: one request per cycle while codes fit one segment and the output does not stall;
// a code of T bits takes ceil(T / segment size) segments, an overflow takes one
// reset: pipeline and output empty, divisor 1, signed mode off
module golomb_encoder #(
  parameter int VALUE_BITS   = 16,
  parameter int SEGMENT_BITS = 32,
  parameter int MAX_QUOTIENT = 1984
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [gmb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gmb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  gmb_in_if.sink                         in_if,
  gmb_out_if.source                      out_if
);

  localparam int NW    = VALUE_BITS + 1;
  localparam int ZW    = $clog2(MAX_QUOTIENT + 1);
  localparam int SEG_W = (SEGMENT_BITS < 32) ? SEGMENT_BITS : 32;

  logic [gmb_pkg::DIV_W-1:0] m_r, kk_r;
  logic                      signed_r;
  logic [gmb_pkg::B_W-1:0]   b_r, b_nxt;
  logic [gmb_pkg::DIV_W:0]   pow2;

  logic                      en, take;
  logic                      s0_v_r;
  logic [NW-1:0]             n_r, n_nxt;
  logic [VALUE_BITS-1:0]     neg;

  logic                      v_c   [0:NW];
  logic [gmb_pkg::DIV_W-1:0] rem_c [0:NW];
  logic [NW-1:0]             dvd_c [0:NW];
  logic [NW-1:0]             quo_c [0:NW];

  logic                       p_v, p_ovf;
  logic [ZW-1:0]              p_z;
  logic [gmb_pkg::LEN_W-1:0]  p_tl;
  logic [gmb_pkg::TAIL_W-1:0] p_tail;

  // configuration; divisor zero acts as one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r      <= gmb_pkg::DIV_W'(1);
      signed_r <= 1'b0;
    end else if (cfg_we) begin
      case (gmb_pkg::cfg_reg_t'(cfg_index))
        gmb_pkg::REG_DIVISOR: begin
          m_r <= (cfg_wdata == '0) ? gmb_pkg::DIV_W'(1) : cfg_wdata;
        end
        gmb_pkg::REG_SIGNED_MODE: begin
          signed_r <= cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  // b = floor(log2 m), k = 2^(b+1) - m
  always_comb begin
    b_nxt = '0;
    for (int i = 1; i < gmb_pkg::DIV_W; i++) begin
      if (m_r[i]) begin
        b_nxt = gmb_pkg::B_W'(i);
      end
    end
    // shift amount one bit wider so b = 15 gives 2^16
    pow2 = (gmb_pkg::DIV_W + 1)'(1) << ((gmb_pkg::B_W + 1)'(b_r) + 1'b1);
  end

  always_ff @(posedge clk) begin
    b_r  <= b_nxt;
    kk_r <= gmb_pkg::DIV_W'(pow2 - {1'b0, m_r});
  end

  assign en          = !p_v || take;
  assign in_if.ready = en;

  // fold in signed mode: n >= 0 -> 2n, n < 0 -> -2n-1; unsigned values pass through
  always_comb begin
    neg = ~in_if.value + 1'b1;
    if (signed_r && in_if.value[VALUE_BITS-1]) begin
      n_nxt = {neg, 1'b0} - 1'b1;
    end else if (signed_r) begin
      n_nxt = {in_if.value, 1'b0};
    end else begin
      n_nxt = {1'b0, in_if.value};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r <= n_nxt;
    end
  end

  assign v_c[0]   = s0_v_r;
  assign rem_c[0] = '0;
  assign dvd_c[0] = n_r;
  assign quo_c[0] = '0;

  for (genvar g = 0; g < NW; g++) begin : g_div
    gmb_div_stage #(.NW(NW)) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .m     (m_r),
      .v_i   (v_c[g]),
      .rem_i (rem_c[g]),
      .dvd_i (dvd_c[g]),
      .quo_i (quo_c[g]),
      .v_o   (v_c[g+1]),
      .rem_o (rem_c[g+1]),
      .dvd_o (dvd_c[g+1]),
      .quo_o (quo_c[g+1])
    );
  end

  gmb_post #(
    .NW           (NW),
    .ZW           (ZW),
    .SEG_W        (SEG_W),
    .MAX_QUOTIENT (MAX_QUOTIENT)
  ) u_post (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_i    (v_c[NW]),
    .q_i    (quo_c[NW]),
    .r_i    (rem_c[NW]),
    .b_i    (b_r),
    .kk_i   (kk_r),
    .v_o    (p_v),
    .ovf_o  (p_ovf),
    .z_o    (p_z),
    .tl_o   (p_tl),
    .tail_o (p_tail)
  );

  gmb_emit #(
    .ZW    (ZW),
    .SEG_W (SEG_W)
  ) u_emit (
    .clk    (clk),
    .rst_n  (rst_n),
    .v_i    (p_v),
    .ovf_i  (p_ovf),
    .z_i    (p_z),
    .tl_i   (p_tl),
    .tail_i (p_tail),
    .take_o (take),
    .out_if (out_if)
  );

endmodule

FILE: src/gmb_div_stage.sv
// gmb_div_stage: one registered step of the restoring divider, one quotient bit
// depends on gmb_pkg for the divisor width
module gmb_div_stage #(
  parameter int NW = 17
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic [gmb_pkg::DIV_W-1:0] m,
  input  logic                      v_i,
  input  logic [gmb_pkg::DIV_W-1:0] rem_i,
  input  logic [NW-1:0]             dvd_i,
  input  logic [NW-1:0]             quo_i,
  output logic                      v_o,
  output logic [gmb_pkg::DIV_W-1:0] rem_o,
  output logic [NW-1:0]             dvd_o,
  output logic [NW-1:0]             quo_o
);

  logic                      v_r;
  logic [gmb_pkg::DIV_W-1:0] rem_r, rem_nxt;
  logic [NW-1:0]             dvd_r, quo_r;
  logic [gmb_pkg::DIV_W:0]   trial, diff;
  logic                      ge;

  always_comb begin
    trial   = {rem_i, dvd_i[NW-1]};
    diff    = trial - {1'b0, m};
    ge      = (trial >= {1'b0, m});
    rem_nxt = ge ? diff[gmb_pkg::DIV_W-1:0] : trial[gmb_pkg::DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_i[NW-2:0], 1'b0};
      quo_r <= {quo_i[NW-2:0], ge};
    end
  end

  assign v_o   = v_r;
  assign rem_o = rem_r;
  assign dvd_o = dvd_r;
  assign quo_o = quo_r;

endmodule

FILE: src/gmb_post.sv
// gmb_post: truncated binary remainder code, limit checks, tail alignment
// depends on gmb_pkg; fed by the last divider stage, feeds gmb_emit
module gmb_post #(
  parameter int NW           = 17,
  parameter int ZW           = 11,
  parameter int SEG_W        = 32,
  parameter int MAX_QUOTIENT = 1984
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       v_i,
  input  logic [NW-1:0]              q_i,
  input  logic [gmb_pkg::DIV_W-1:0]  r_i,
  input  logic [gmb_pkg::B_W-1:0]    b_i,
  input  logic [gmb_pkg::DIV_W-1:0]  kk_i,
  output logic                       v_o,
  output logic                       ovf_o,
  output logic [ZW-1:0]              z_o,
  output logic [gmb_pkg::LEN_W-1:0]  tl_o,
  output logic [gmb_pkg::TAIL_W-1:0] tail_o
);

  localparam int TW       = (NW + 1 > 13) ? NW + 1 : 13;
  localparam int MAX_BITS = gmb_pkg::MAX_RESULTS * SEG_W;

  logic                       lt;
  logic [gmb_pkg::LEN_W-1:0]  rem_len;
  logic [gmb_pkg::DIV_W-1:0]  rem_code, code_la;
  logic [TW-1:0]              total;
  logic                       ovf_nxt;

  logic                       v_r, ovf_r;
  logic [ZW-1:0]              z_r;
  logic [gmb_pkg::LEN_W-1:0]  tl_r;
  logic [gmb_pkg::TAIL_W-1:0] tail_r;

  always_comb begin
    lt       = (r_i < kk_i);
    rem_len  = lt ? gmb_pkg::LEN_W'(b_i) : gmb_pkg::LEN_W'(b_i) + 1'b1;
    rem_code = lt ? r_i : r_i + kk_i;
    // left align the remainder code under the terminating one
    code_la  = rem_code << (gmb_pkg::LEN_W'(gmb_pkg::DIV_W) - rem_len);
    total    = TW'(q_i) + TW'(rem_len) + TW'(1);
    ovf_nxt  = (TW'(q_i) > TW'(MAX_QUOTIENT)) || (total > TW'(MAX_BITS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r  <= ovf_nxt;
      z_r    <= ZW'(q_i);
      tl_r   <= rem_len + 1'b1;
      tail_r <= {1'b1, code_la};
    end
  end

  assign v_o    = v_r;
  assign ovf_o  = ovf_r;
  assign z_o    = z_r;
  assign tl_o   = tl_r;
  assign tail_o = tail_r;

endmodule

FILE: src/gmb_emit.sv
// gmb_emit: splits one code into segments and holds the output register
// depends on gmb_pkg and gmb_out_if
module gmb_emit #(
  parameter int ZW    = 11,
  parameter int SEG_W = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       v_i,
  input  logic                       ovf_i,
  input  logic [ZW-1:0]              z_i,
  input  logic [gmb_pkg::LEN_W-1:0]  tl_i,
  input  logic [gmb_pkg::TAIL_W-1:0] tail_i,
  output logic                       take_o,
  gmb_out_if.source                  out_if
);

  localparam int CW = ((ZW > 6) ? ZW : 6) + 1;
  localparam int WW = gmb_pkg::CODE_W + gmb_pkg::TAIL_W;
  localparam logic [gmb_pkg::CODE_W-1:0] SEG_MASK = ~({gmb_pkg::CODE_W{1'b1}} >> SEG_W);

  // item being split
  logic                       it_v_r, ovf_r;
  logic [ZW-1:0]              z_r, z_nxt;
  logic [gmb_pkg::LEN_W-1:0]  tl_r, tl_nxt;
  logic [gmb_pkg::TAIL_W-1:0] tail_r, tail_nxt;

  // output register
  logic                       out_v_r, out_last_r, out_ovf_r;
  logic [gmb_pkg::CODE_W-1:0] out_code_r;
  logic [gmb_pkg::CNT_W-1:0]  out_cnt_r;

  logic [CW-1:0]              zx, tot;
  logic [WW-1:0]              wide, left;
  logic [gmb_pkg::CODE_W-1:0] seg_code;
  logic [gmb_pkg::CNT_W-1:0]  seg_cnt;
  logic                       seg_last, seg_load;

  always_comb begin
    zx       = CW'(z_r);
    tot      = zx + CW'(tl_r);
    wide     = {tail_r, gmb_pkg::CODE_W'(0)} >> zx[5:0];
    left     = wide << SEG_W;
    seg_code = '0;
    seg_cnt  = gmb_pkg::CNT_W'(SEG_W);
    seg_last = 1'b0;
    z_nxt    = z_r;
    tl_nxt   = tl_r;
    tail_nxt = tail_r;
    if (ovf_r) begin
      seg_cnt  = '0;
      seg_last = 1'b1;
    end else if (zx >= CW'(SEG_W)) begin
      // whole segment of quotient zeros
      z_nxt = ZW'(zx - CW'(SEG_W));
    end else begin
      seg_code = wide[WW-1 -: gmb_pkg::CODE_W] & SEG_MASK;
      if (tot <= CW'(SEG_W)) begin
        seg_last = 1'b1;
        seg_cnt  = gmb_pkg::CNT_W'(tot);
      end
      z_nxt    = '0;
      tl_nxt   = gmb_pkg::LEN_W'(tot - CW'(SEG_W));
      tail_nxt = left[WW-1 -: gmb_pkg::TAIL_W];
    end
  end

  assign seg_load = it_v_r && (!out_v_r || out_if.ready);
  assign take_o   = !it_v_r || (seg_load && seg_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (take_o) begin
        it_v_r <= v_i;
      end
      if (seg_load) begin
        out_v_r <= 1'b1;
      end else if (out_if.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_o) begin
      ovf_r  <= ovf_i;
      z_r    <= z_i;
      tl_r   <= tl_i;
      tail_r <= tail_i;
    end else if (seg_load) begin
      z_r    <= z_nxt;
      tl_r   <= tl_nxt;
      tail_r <= tail_nxt;
    end
    if (seg_load) begin
      out_code_r <= seg_code;
      out_cnt_r  <= seg_cnt;
      out_last_r <= seg_last;
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_if.valid     = out_v_r;
  assign out_if.code_bits = out_code_r;
  assign out_if.bit_count = out_cnt_r;
  assign out_if.last      = out_last_r;
  assign out_if.overflow  = out_ovf_r;

endmodule

FILE: bench/tb_top.sv
// tb_top: self-checking bench for golomb_encoder, directed then random requests
// depends on gmb_pkg, gmb_in_if, gmb_out_if and the golomb_encoder rtl
// expected code segments come from an in-bench encoder and are checked in order
module tb_top;

  localparam int VALUE_W    = 16;
  localparam int SEG_W      = 32;
  localparam int QUOT_LIMIT = 1984;
  localparam int HOLD_CYCLES = 300;
  localparam int TIMEOUT    = 10_000_000;

  typedef struct packed {
    logic [gmb_pkg::CODE_W-1:0] code_bits;
    logic [gmb_pkg::CNT_W-1:0]  bit_count;
    logic                       last;
    logic                       overflow;
  } segment_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  gmb_pkg::cfg_reg_t              cfg_index;
  logic [gmb_pkg::CFG_DATA_W-1:0] cfg_wdata;

  gmb_in_if #(.VALUE_BITS(VALUE_W)) in_ch ();
  gmb_out_if out_ch ();

  golomb_encoder #(
    .VALUE_BITS  (VALUE_W),
    .SEGMENT_BITS(SEG_W),
    .MAX_QUOTIENT(QUOT_LIMIT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_if    (in_ch),
    .out_if   (out_ch)
  );

  segment_t                   pending_segs[$];
  logic [gmb_pkg::DIV_W-1:0]  cur_divisor;
  logic                       cur_signed;
  int                         mismatches;
  bit                         quiet_tx;
  bit                         quiet_rx;
  bit                         hold_out;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(TIMEOUT);
    $display("tb_top: done, errors");
    $finish;
  end

  // most gaps short, a few long
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // fold, divide, unary quotient, truncated binary remainder, split into segments; past a limit one overflow segment
  function automatic void encode_value(input logic [VALUE_W-1:0] v);
    int unsigned n, m, q, r, b, kk, rlen, rcode, total, pos, off;
    segment_t    seg;
    if (cur_signed && v[VALUE_W-1]) n = 2 * ((1 << VALUE_W) - int'(v)) - 1;
    else if (cur_signed) n = 2 * int'(v);
    else n = int'(v);
    m = (cur_divisor == '0) ? 1 : int'(cur_divisor);
    q = n / m;
    r = n % m;
    b = 0;
    while ((m >> (b + 1)) != 0) b++;
    kk = (1 << (b + 1)) - m;
    if (r < kk) begin
      rlen  = b;
      rcode = r;
    end else begin
      rlen  = b + 1;
      rcode = r + kk;
    end
    total = q + 1 + rlen;
    if (q > QUOT_LIMIT || (total + SEG_W - 1) / SEG_W > gmb_pkg::MAX_RESULTS) begin
      seg           = '0;
      seg.last      = 1'b1;
      seg.overflow  = 1'b1;
      pending_segs.push_back(seg);
      return;
    end
    seg = '0;
    for (pos = 0; pos < total; pos++) begin
      off = pos % SEG_W;
      if (pos < q) seg.code_bits[31-off] = 1'b0;
      else if (pos == q) seg.code_bits[31-off] = 1'b1;
      else seg.code_bits[31-off] = 1'((rcode >> (rlen - 1 - (pos - q - 1))) & 1);
      seg.bit_count = gmb_pkg::CNT_W'(off + 1);
      if (off == SEG_W - 1 || pos == total - 1) begin
        seg.last = (pos == total - 1);
        pending_segs.push_back(seg);
        seg = '0;
      end
    end
  endfunction

  // random value aimed at a chosen quotient so long codes and overflow show up
  function automatic logic [VALUE_W-1:0] random_value();
    int unsigned m, q, qmax, n, sel;
    m    = (cur_divisor == '0) ? 1 : int'(cur_divisor);
    qmax = 65535 / m;
    sel  = $urandom_range(0, 99);
    if (sel < 15) return VALUE_W'($urandom);
    if (sel < 75) q = $urandom_range(0, 6);
    else if (sel < 95) q = $urandom_range(7, 300);
    else q = $urandom_range(1900, 2100);
    if (q > qmax) q = $urandom_range(0, qmax);
    n = q * m + $urandom_range(0, m - 1);
    if (n > 65535) n = n - m;
    if (!cur_signed) return VALUE_W'(n);
    if (n % 2 == 0) return VALUE_W'(n >> 1);
    return VALUE_W'(32'd65536 - (n + 1) / 2);
  endfunction

  function automatic void report(input string what, input segment_t want, input segment_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch: %s want %h/%0d/%b/%b got %h/%0d/%b/%b", what,
               want.code_bits, want.bit_count, want.last, want.overflow,
               got.code_bits, got.bit_count, got.last, got.overflow);
  endfunction

  always @(posedge clk) begin
    segment_t got;
    segment_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.code_bits = out_ch.code_bits;
      got.bit_count = out_ch.bit_count;
      got.last      = out_ch.last;
      got.overflow  = out_ch.overflow;
      if (pending_segs.size() == 0) begin
        report("segment with nothing pending", '0, got);
      end else begin
        want = pending_segs.pop_front();
        if (got.code_bits !== want.code_bits || got.bit_count !== want.bit_count ||
            got.last !== want.last || got.overflow !== want.overflow)
          report("field", want, got);
      end
    end
  end

  // receiver: random stalls, a quiet mode, and a long hold-off on demand
  initial begin
    int rx_gap;
    rx_gap = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (rx_gap > 0 && !quiet_rx) begin
        out_ch.ready <= 1'b0;
        rx_gap--;
      end else begin
        out_ch.ready <= 1'b1;
        rx_gap = 0;
        if (!quiet_rx && $urandom_range(0, 9) == 0) rx_gap = pick_gap();
      end
    end
  end

  // both registers, one write per cycle, only while idle
  task automatic write_config(input logic [gmb_pkg::DIV_W-1:0] div, input logic sm);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= gmb_pkg::REG_DIVISOR;
    cfg_wdata <= div;
    @(posedge clk);
    cfg_index <= gmb_pkg::REG_SIGNED_MODE;
    cfg_wdata <= {{(gmb_pkg::CFG_DATA_W-1){1'b0}}, sm};
    @(posedge clk);
    cfg_we      <= 1'b0;
    cur_divisor = div;
    cur_signed  = sm;
  endtask

  task automatic send_value(input logic [VALUE_W-1:0] v);
    int gap;
    gap = 0;
    if (!quiet_tx && $urandom_range(0, 3) == 0) gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    encode_value(v);
  endtask

  // sender pauses until every pending segment has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_segs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_reset_config();
    send_value(16'd0);
    send_value(16'd31);
    send_value(16'd32);
    send_value(16'd1984);
    send_value(16'd1985);
    send_value(16'hFFFF);
    drain();
  endtask

  task automatic test_divisor_extremes();
    write_config(16'hFFFF, 1'b0);
    send_value(16'd0);
    send_value(16'd1);
    send_value(16'hFFFE);
    send_value(16'hFFFF);
    drain();
    // zero divisor acts as one
    write_config(16'd0, 1'b0);
    send_value(16'd3);
    drain();
    write_config(16'h8000, 1'b0);
    send_value(16'h7FFF);
    send_value(16'h8000);
    drain();
    // quotient right at the limit and one past it
    write_config(16'd33, 1'b0);
    send_value(16'd65504);
    send_value(16'd65505);
    drain();
    write_config(16'd3, 1'b0);
    send_value(16'd2);
    drain();
  endtask

  task automatic test_signed_fold();
    write_config(16'd4, 1'b1);
    send_value(16'd0);
    send_value(16'd1);
    send_value(16'hFFFF);
    send_value(16'h7FFF);
    send_value(16'h8000);
    drain();
    write_config(16'hFFFF, 1'b1);
    send_value(16'h7FFF);
    send_value(16'h8000);
    send_value(16'hFFFE);
    drain();
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    write_config(16'd3, 1'b0);
    quiet_tx = 1'b1;
    hold_out = 1'b1;
    repeat (24) send_value(VALUE_W'($urandom_range(0, 60)));
    quiet_tx = 1'b0;
    drain();
  endtask

  task automatic test_random_phase(input int count, input logic [gmb_pkg::DIV_W-1:0] div,
                                   input logic sm);
    write_config(div, sm);
    repeat (count) send_value(random_value());
    drain();
  endtask

  task automatic test_random();
    quiet_tx = 1'b1;
    quiet_rx = 1'b1;
    test_random_phase(25, 16'd5, 1'b0);
    quiet_tx = 1'b0;
    quiet_rx = 1'b0;
    test_random_phase(25, gmb_pkg::DIV_W'($urandom_range(1, 65535)), 1'b1);
    test_random_phase(25, gmb_pkg::DIV_W'(1 << $urandom_range(0, 15)), 1'b0);
    test_random_phase(25, gmb_pkg::DIV_W'($urandom_range(2, 40)), 1'b1);
    test_random_phase(25, gmb_pkg::DIV_W'($urandom_range(1, 65535)), 1'b0);
  endtask

  initial begin
    mismatches  = 0;
    quiet_tx    = 1'b0;
    quiet_rx    = 1'b0;
    hold_out    = 1'b0;
    cur_divisor = 16'd1;
    cur_signed  = 1'b0;
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= gmb_pkg::REG_DIVISOR;
    cfg_wdata   <= '0;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_config();
    test_divisor_extremes();
    test_signed_fold();
    test_backpressure();
    test_random();

    repeat (30) @(posedge clk);
    if (pending_segs.size() != 0) begin
      mismatches += pending_segs.size();
      $display("%0d expected segments never arrived", pending_segs.size());
    end
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
